### design/frame_reorder_with_skip_unit_assert.svh
// Assertion macros for the reorder unit; clock and reset are taken from the including module.
`ifndef FRAME_REORDER_WITH_SKIP_UNIT_ASSERT_SVH
`define FRAME_REORDER_WITH_SKIP_UNIT_ASSERT_SVH

// condition holds at every edge outside reset
`define FRWS_CHECK(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("frws: invariant broken");

// antecedent at one edge implies consequent at the next
`define FRWS_CHECK_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("frws: sequence broken");

`endif

### design/frws_pkg.sv
`default_nettype none

package frws_pkg;

   localparam int ID_W       = 32;
   localparam int HANDLE_W   = 16;
   localparam int LIMIT_W    = 4;
   localparam int RESULT_CAP = 16;
   localparam int N_W        = $clog2(RESULT_CAP + 1);

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;
   localparam logic [ID_W-1:0]    ID_ONE      = 32'd1;
   localparam logic [N_W-1:0]     N_ONE       = 5'd1;
   localparam logic [N_W-1:0]     N_CAP       = 5'd16;

   localparam logic [1:0] OP_HOLD   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_POP    = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]     seq_id;
      logic [HANDLE_W-1:0] payload_handle;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]     out_seq_id;
      logic [HANDLE_W-1:0] out_handle;
      logic                run_last;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic [ID_W-1:0]     id;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   typedef struct packed {
      logic [1:0]          op;
      logic [ID_W-1:0]     id;
      logic [HANDLE_W-1:0] handle;
   } cell_cmd_type;

endpackage

`default_nettype wire

### design/frws_cell.sv
`default_nettype none

// One place of the sorted hold chain, ordered by {id, slot}, smallest at the head.
module frws_cell #(
   parameter int SLOT_W = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire frws_pkg::cell_cmd_type cmd,
   input  wire logic [SLOT_W-1:0]      cmd_slot,
   input  wire frws_pkg::entry_type    prev_ent,
   input  wire logic [SLOT_W-1:0]      prev_slot,
   input  wire logic                   prev_lt,
   input  wire frws_pkg::entry_type    next_ent,
   input  wire logic [SLOT_W-1:0]      next_slot,
   output frws_pkg::entry_type         ent,
   output logic [SLOT_W-1:0]           slot,
   output logic                        lt
);

   logic                          valid_ff, valid_in;
   logic [frws_pkg::ID_W-1:0]     id_ff, id_in;
   logic [frws_pkg::HANDLE_W-1:0] handle_ff, handle_in;
   logic [SLOT_W-1:0]             slot_ff, slot_in;

   assign lt = !valid_ff || ({cmd.id, cmd_slot} < {id_ff, slot_ff});

   always_comb begin
      valid_in  = valid_ff;
      id_in     = id_ff;
      handle_in = handle_ff;
      slot_in   = slot_ff;
      unique case (cmd.op)
         frws_pkg::OP_INSERT: begin
            priority if (lt && !prev_lt) begin
               valid_in  = 1'b1;
               id_in     = cmd.id;
               handle_in = cmd.handle;
               slot_in   = cmd_slot;
            end else if (lt) begin
               valid_in  = prev_ent.valid;
               id_in     = prev_ent.id;
               handle_in = prev_ent.handle;
               slot_in   = prev_slot;
            end else begin
            end
         end
         frws_pkg::OP_POP: begin
            valid_in  = next_ent.valid;
            id_in     = next_ent.id;
            handle_in = next_ent.handle;
            slot_in   = next_slot;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff     <= id_in;
      handle_ff <= handle_in;
      slot_ff   <= slot_in;
   end

   assign ent  = '{valid: valid_ff, id: id_ff, handle: handle_ff};
   assign slot = slot_ff;

endmodule

`default_nettype wire

### design/frws_free_slot.sv
`default_nettype none

// Lowest free slot of the occupancy map, registered.
module frws_free_slot #(
   parameter int DEPTH  = 16,
   parameter int SLOT_W = 4
) (
   input  wire logic              clock,
   input  wire logic [DEPTH-1:0]  used,
   output logic [SLOT_W-1:0]      free_slot
);

   logic [DEPTH-1:0]  free_map;
   logic [DEPTH-1:0]  lowest;
   logic [SLOT_W-1:0] slot_in;
   logic [SLOT_W-1:0] slot_ff;

   assign free_map = ~used;
   assign lowest   = free_map & (~free_map + {{(DEPTH-1){1'b0}}, 1'b1});

   always_comb begin
      slot_in = '0;
      for (int i = 0; i < DEPTH; i++) begin
         slot_in = slot_in | (lowest[i] ? SLOT_W'(i) : '0);
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign free_slot = slot_ff;

endmodule

`default_nettype wire

### design/frame_reorder_with_skip_unit.sv
// channel  direction  handshake                  payload
// req      in         start high, busy low       req_item  (seq_id, payload_handle)
// rsp      out        rsp_strobe, one cycle      rsp_item  (out_seq_id, out_handle, run_last)
// csr      in         csr_valid and csr_ready    csr_data  (hold_limit)
//
// An item holds busy through the insert, skip and drain states, draining 0 to 16 held frames,
// so a new item is taken only once the last is done; the chain head pops one held frame per cycle.
// A result waits in a pending register until the next one is found or the run closes, and is then
// registered out; run_last marks the final one. Synchronous reset empties the chain and sets the
// expected id to zero, limit to 8. Results cannot be stalled; csr_ready is always high.
`default_nettype none

module frame_reorder_with_skip_unit #(
   parameter int HOLD_DEPTH = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire frws_pkg::req_type              req_item,
   output logic                                rsp_strobe,
   output frws_pkg::rsp_type                   rsp_item,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [frws_pkg::LIMIT_W-1:0]   csr_data
);

   `include "frame_reorder_with_skip_unit_assert.svh"

   localparam int SLOT_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
   localparam int CNT_W  = $clog2(HOLD_DEPTH + 1);
   localparam int CMP_W  = (CNT_W > frws_pkg::LIMIT_W) ? CNT_W : frws_pkg::LIMIT_W;
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HOLD_DEPTH);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_INS   = 2'd1;
   localparam logic [1:0] ST_SKIP  = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   logic [1:0]                        state_ff, state_in;
   frws_pkg::req_type                 req_ff, req_in;
   logic [frws_pkg::ID_W-1:0]         next_exp_ff, next_exp_in;
   logic [frws_pkg::LIMIT_W-1:0]      hold_limit_ff, hold_limit_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [HOLD_DEPTH-1:0]             used_ff, used_in;
   logic [frws_pkg::N_W-1:0]          n_ff, n_in;
   logic                              pend_valid_ff, pend_valid_in;
   frws_pkg::rsp_type                 pend_ff, pend_in;
   logic                              rsp_strobe_ff, rsp_strobe_in;
   frws_pkg::rsp_type                 rsp_ff, rsp_in;

   frws_pkg::cell_cmd_type            cmd;
   logic [SLOT_W-1:0]                 free_slot;
   frws_pkg::entry_type               cell_ent  [HOLD_DEPTH];
   logic [SLOT_W-1:0]                 cell_slot [HOLD_DEPTH];
   logic [HOLD_DEPTH-1:0]             cell_lt;
   frws_pkg::entry_type               empty_ent;
   logic                              over_limit;
   logic                              head_match;
   logic                              produce;
   frws_pkg::rsp_type                 produced;

   assign empty_ent = '0;

   frws_free_slot #(
      .DEPTH  (HOLD_DEPTH),
      .SLOT_W (SLOT_W)
   ) u_free_slot (
      .clock     (clock),
      .used      (used_ff),
      .free_slot (free_slot)
   );

   for (genvar g = 0; g < HOLD_DEPTH; g++) begin : g_cell
      frws_pkg::entry_type prev_ent, next_ent;
      logic [SLOT_W-1:0]   prev_slot, next_slot;
      logic                prev_lt;
      if (g == 0) begin : g_head
         assign prev_ent  = empty_ent;
         assign prev_slot = '0;
         assign prev_lt   = 1'b0;
      end else begin : g_body
         assign prev_ent  = cell_ent[g-1];
         assign prev_slot = cell_slot[g-1];
         assign prev_lt   = cell_lt[g-1];
      end
      if (g == HOLD_DEPTH - 1) begin : g_tail
         assign next_ent  = empty_ent;
         assign next_slot = '0;
      end else begin : g_inner
         assign next_ent  = cell_ent[g+1];
         assign next_slot = cell_slot[g+1];
      end
      frws_cell #(
         .SLOT_W (SLOT_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .cmd_slot  (free_slot),
         .prev_ent  (prev_ent),
         .prev_slot (prev_slot),
         .prev_lt   (prev_lt),
         .next_ent  (next_ent),
         .next_slot (next_slot),
         .ent       (cell_ent[g]),
         .slot      (cell_slot[g]),
         .lt        (cell_lt[g])
      );
   end

   assign over_limit = (CMP_W'(count_ff) > CMP_W'(hold_limit_ff)) || (count_ff == CNT_FULL);
   assign head_match = cell_ent[0].valid && (cell_ent[0].id == next_exp_ff) &&
                       (n_ff < frws_pkg::N_CAP);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      next_exp_in   = next_exp_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      n_in          = n_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      produce       = 1'b0;
      produced      = '0;
      cmd           = '{op: frws_pkg::OP_HOLD, id: req_ff.seq_id,
                        handle: req_ff.payload_handle};

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_item;
               state_in = ST_INS;
            end
         end
         ST_INS: begin
            n_in = '0;
            if (req_ff.seq_id == next_exp_ff) begin
               produce     = 1'b1;
               produced    = '{out_seq_id: req_ff.seq_id, out_handle: req_ff.payload_handle,
                               run_last: 1'b0};
               next_exp_in = next_exp_ff + frws_pkg::ID_ONE;
               n_in        = frws_pkg::N_ONE;
            end else if (count_ff != CNT_FULL) begin
               cmd.op             = frws_pkg::OP_INSERT;
               used_in[free_slot] = 1'b1;
               count_in           = count_ff + CNT_ONE;
            end
            state_in = ST_SKIP;
         end
         ST_SKIP: begin
            if (over_limit && cell_ent[0].valid) begin
               next_exp_in = cell_ent[0].id;
            end
            state_in = ST_DRAIN;
         end
         default: begin
            if (head_match) begin
               produce                = 1'b1;
               produced               = '{out_seq_id: cell_ent[0].id,
                                          out_handle: cell_ent[0].handle, run_last: 1'b0};
               cmd.op                 = frws_pkg::OP_POP;
               used_in[cell_slot[0]]  = 1'b0;
               count_in               = count_ff - CNT_ONE;
               next_exp_in            = next_exp_ff + frws_pkg::ID_ONE;
               n_in                   = n_ff + frws_pkg::N_ONE;
            end else begin
               // close the run: the waiting item is the last one
               rsp_strobe_in   = pend_valid_ff;
               rsp_in          = pend_ff;
               rsp_in.run_last = 1'b1;
               pend_valid_in   = 1'b0;
               state_in        = ST_IDLE;
            end
         end
      endcase

      if (produce) begin
         rsp_strobe_in   = pend_valid_ff;
         rsp_in          = pend_ff;
         rsp_in.run_last = 1'b0;
         pend_in         = produced;
         pend_valid_in   = 1'b1;
      end
   end

   assign hold_limit_in = (csr_valid && csr_ready) ? csr_data : hold_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         next_exp_ff   <= '0;
         hold_limit_ff <= frws_pkg::LIMIT_RESET;
         count_ff      <= '0;
         used_ff       <= '0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_exp_ff   <= next_exp_in;
         hold_limit_ff <= hold_limit_in;
         count_ff      <= count_in;
         used_ff       <= used_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   `FRWS_CHECK(a_count_map, $countones(used_ff) == int'(count_ff))
   `FRWS_CHECK(a_head_count, cell_ent[0].valid == (count_ff != '0))
   `FRWS_CHECK_NEXT(a_last_gap, rsp_strobe_ff && rsp_ff.run_last, !rsp_strobe_ff)
   `FRWS_CHECK_NEXT(a_idle_flush, !busy, !pend_valid_ff)

endmodule

`default_nettype wire
